@@ rtl/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

  localparam int DEF_MAX_ROWS = 32;
  localparam int DEF_MAX_COLS = 128;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd1;

  localparam logic [5:0] RESET_ROWS = 6'd25;
  localparam logic [7:0] RESET_COLS = 8'd80;

  localparam logic [7:0] NEWLINE_CHAR = 8'd10;
  localparam logic [7:0] SPACE_CHAR   = 8'd32;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  typedef struct packed {
    logic clr_step;
    logic load_item;
    logic exec;
    logic scr_rd;
    logic scr_wr;
    logic fill;
    logic calc;
    logic out_load;
  } tcw_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_read;
    logic scroll;
    logic one_row;
    logic row_end;
    logic move_last;
    logic out_free;
  } tcw_sts_t;

endpackage

`default_nettype wire

@@ rtl/tcw_datapath.sv @@
`default_nettype none

module tcw_datapath import tcw_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [7:0]            cfg_data,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  in_tuser,
  input  wire logic                  out_tready,
  output logic                       out_tvalid,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire tcw_cmd_t              cmd,
  output tcw_sts_t                   sts
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int ERW   = $clog2(MAX_ROWS + 1);
  localparam int ECW   = $clog2(MAX_COLS + 1);
  localparam logic [6:0]    MAXR    = 7'(MAX_ROWS);
  localparam logic [8:0]    MAXC    = 9'(MAX_COLS);
  localparam logic [AW-1:0] ROW_STEP = AW'(MAX_COLS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  logic [5:0]    cfg_rows_r;
  logic [7:0]    cfg_cols_r;
  logic          func_r;
  logic [7:0]    ch_r;
  logic [4:0]    rrow_r;
  logic [6:0]    rcol_r;
  logic [CW-1:0] cur_col_r;
  logic [RW-1:0] cur_row_r;
  logic          scrolled_r;
  logic          rd_ok_r;
  logic [CW-1:0] sc_r;
  logic [RW-1:0] sr_r;
  logic [AW-1:0] base_r;
  logic [AW-1:0] clr_r;
  logic [7:0]    rdata_r;
  logic [15:0]   prod_r;
  logic          out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic [7:0]    mem [DEPTH];

  logic [6:0]     rows_w, rows_sat;
  logic [8:0]     cols_w, cols_sat;
  logic [ERW-1:0] eff_rows;
  logic [ECW-1:0] eff_cols;
  logic [ECW-1:0] col_ext, x, x_inc, x_new;
  logic [ERW-1:0] row_ext, y, y_inc, y_new;
  logic           nl, wrap, next_line, scroll;
  logic           rd_ok;
  logic [AW-1:0]  put_addr, rd_addr;
  logic           we, re;
  logic [AW-1:0]  waddr, raddr;
  logic [7:0]     wdata;
  logic [15:0]    cell_idx;
  logic [31:0]    row_wide, col_wide;
  logic [7:0]     rch;

  always_comb begin
    rows_w   = {1'b0, cfg_rows_r};
    rows_sat = (rows_w == 7'd0) ? 7'd1 : ((rows_w > MAXR) ? MAXR : rows_w);
    cols_w   = {1'b0, cfg_cols_r};
    cols_sat = (cols_w == 9'd0) ? 9'd1 : ((cols_w > MAXC) ? MAXC : cols_w);
    eff_rows = rows_sat[ERW-1:0];
    eff_cols = cols_sat[ECW-1:0];
  end

  always_comb begin
    col_ext   = ECW'(cur_col_r);
    row_ext   = ERW'(cur_row_r);
    x         = (col_ext >= eff_cols) ? eff_cols - ECW'(1) : col_ext;
    y         = (row_ext >= eff_rows) ? eff_rows - ERW'(1) : row_ext;
    nl        = (ch_r == NEWLINE_CHAR);
    x_inc     = x + ECW'(1);
    wrap      = (x_inc >= eff_cols);
    next_line = nl || wrap;
    x_new     = next_line ? '0 : x_inc;
    y_inc     = y + ERW'(1);
    scroll    = next_line && (y_inc >= eff_rows);
    y_new     = (next_line && !scroll) ? y_inc : y;
    put_addr  = AW'(32'(y) * MAX_COLS + 32'(x));
    rd_addr   = AW'(32'(rrow_r) * MAX_COLS + 32'(rcol_r));
    rd_ok     = (8'(rrow_r) < 8'(eff_rows)) && (9'(rcol_r) < 9'(eff_cols));
  end

  always_comb begin
    sts.clr_last  = (clr_r == LAST_ADDR);
    sts.is_read   = func_r;
    sts.scroll    = scroll;
    sts.one_row   = (eff_rows == ERW'(1));
    sts.row_end   = (ECW'(sc_r) == eff_cols - ECW'(1));
    sts.move_last = sts.row_end && (ERW'(sr_r) == eff_rows - ERW'(2));
    sts.out_free  = !out_tvalid_r || out_tready;
  end

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = '0;
    raddr = '0;
    wdata = SPACE_CHAR;
    if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = clr_r;
    end else if (cmd.exec) begin
      if (func_r) begin
        re    = rd_ok;
        raddr = rd_addr;
      end else begin
        we    = !nl;
        waddr = put_addr;
        wdata = ch_r;
      end
    end else if (cmd.scr_rd) begin
      re    = 1'b1;
      raddr = base_r + ROW_STEP + AW'(sc_r);
    end else if (cmd.scr_wr) begin
      we    = 1'b1;
      waddr = base_r + AW'(sc_r);
      wdata = rdata_r;
    end else if (cmd.fill) begin
      we    = 1'b1;
      waddr = base_r + AW'(sc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_comb begin
    cell_idx = prod_r + 16'(cur_col_r);
    row_wide = 32'(cur_row_r);
    col_wide = 32'(cur_col_r);
    rch      = rd_ok_r ? rdata_r : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_rows_r   <= RESET_ROWS;
      cfg_cols_r   <= RESET_COLS;
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_ROWS: cfg_rows_r <= cfg_data[5:0];
          CFG_COLS: cfg_cols_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clr_step) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cmd.exec && !func_r) begin
        cur_col_r <= CW'(x_new);
        cur_row_r <= RW'(y_new);
      end
      if (cmd.out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_r <= in_tuser;
      ch_r   <= in_tdata[7:0];
      rrow_r <= in_tdata[12:8];
      rcol_r <= in_tdata[19:13];
    end
    if (cmd.exec) begin
      rd_ok_r    <= func_r && rd_ok;
      scrolled_r <= !func_r && scroll;
      sc_r       <= '0;
      sr_r       <= '0;
      base_r     <= '0;
    end
    if (cmd.scr_wr) begin
      if (sts.row_end) begin
        sc_r   <= '0;
        sr_r   <= sr_r + RW'(1);
        base_r <= base_r + ROW_STEP;
      end else begin
        sc_r <= sc_r + CW'(1);
      end
    end
    if (cmd.fill) begin
      sc_r <= sc_r + CW'(1);
    end
    if (cmd.calc) begin
      prod_r <= 16'(eff_cols) * 16'(cur_row_r);
    end
    if (cmd.out_load) begin
      out_tdata_r <= {3'b000, rch, scrolled_r, cell_idx[7:0], cell_idx[15:8],
                      row_wide[4:0], col_wide[6:0]};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

@@ rtl/tcw_ctrl.sv @@
`default_nettype none

module tcw_ctrl import tcw_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire tcw_sts_t sts,
  output tcw_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SCR_RD,
    S_SCR_WR,
    S_FILL,
    S_CALC,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (!sts.is_read && sts.scroll) begin
          state_nxt = sts.one_row ? S_FILL : S_SCR_RD;
        end else begin
          state_nxt = S_CALC;
        end
      end
      S_SCR_RD: begin
        cmd.scr_rd = 1'b1;
        state_nxt  = S_SCR_WR;
      end
      S_SCR_WR: begin
        cmd.scr_wr = 1'b1;
        state_nxt  = sts.move_last ? S_FILL : S_SCR_RD;
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (sts.row_end) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_tready = in_tready_r;

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("More than one datapath command issued in one cycle.");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("Output register overwritten while its item was pending.");

  a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scr_wr |-> $past(cmd.scr_rd))
    else $error("Scroll write issued without a preceding read.");

  a_fill_on_put: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill |-> !sts.is_read)
    else $error("Bottom row cleared for a read item.");

endmodule

`default_nettype wire

@@ rtl/text_console_writer_unit.sv @@
// An accepted item passes through the EXEC, CALC and DONE states, and DONE loads its result
// once the output register is free. A put that scrolls also moves cols * (rows - 1) cells
// up, each read and then written, and clears the bottom row's cols cells, one store access
// per cycle. A new item is accepted only after the previous result has been loaded.
// Reset: synchronous, active low; the screen store is then filled with spaces, one cell a
// cycle over all MAX_ROWS * MAX_COLS cells, during which no item is accepted.
`default_nettype none

module text_console_writer_unit import tcw_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [7:0]            cfg_data,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // ch [7:0], read_row [12:8], read_col [19:13], zero fill [23:20]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // func [0]
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // cursor_col [6:0], cursor_row [11:7], cursor_high_byte [19:12],
  // cursor_low_byte [27:20], scrolled [28], read_char [36:29], zero fill [39:37]
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

`default_nettype wire

@@ test/tb_text_console_writer_unit.sv @@
module tb_text_console_writer_unit;
  import tcw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;
  localparam int   CYCLE_LIMIT = 3000000;
  localparam int   SCREEN_CELLS = DEF_MAX_ROWS * DEF_MAX_COLS;

  typedef struct packed {
    logic [7:0] read_char;
    logic       scrolled;
    logic [7:0] low_byte;
    logic [7:0] high_byte;
    logic [4:0] row;
    logic [6:0] col;
  } cursor_report_t;

  class console_screen_tracker;
    logic [7:0]     screen [SCREEN_CELLS];
    logic [6:0]     col_pos;
    logic [4:0]     row_pos;
    logic [5:0]     rows_reg;
    logic [7:0]     cols_reg;
    cursor_report_t expected_reports [$];
    int             failures;

    function new();
      foreach (screen[i]) screen[i] = SPACE_CHAR;
      col_pos  = '0;
      row_pos  = '0;
      rows_reg = RESET_ROWS;
      cols_reg = RESET_COLS;
      failures = 0;
    endfunction

    function int active_rows();
      if (rows_reg == 0) return 1;
      if (rows_reg > DEF_MAX_ROWS) return DEF_MAX_ROWS;
      return rows_reg;
    endfunction

    function int active_cols();
      if (cols_reg == 0) return 1;
      if (cols_reg > DEF_MAX_COLS) return DEF_MAX_COLS;
      return cols_reg;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
      if (idx == CFG_ROWS) rows_reg = value[5:0];
      else if (idx == CFG_COLS) cols_reg = value;
    endfunction

    function void note_item(logic func, logic [7:0] ch, logic [4:0] rrow, logic [6:0] rcol);
      int rows;
      int cols;
      int x;
      int y;
      int cell_index;
      bit next_line;
      cursor_report_t rep;
      rows = active_rows();
      cols = active_cols();
      rep = '0;
      if (func == FUNC_READ) begin
        if (rrow < rows && rcol < cols) rep.read_char = screen[rrow * DEF_MAX_COLS + rcol];
      end else begin
        x = col_pos;
        y = row_pos;
        next_line = 1'b0;
        if (y >= rows) y = rows - 1;
        if (x >= cols) x = cols - 1;
        if (ch == NEWLINE_CHAR) begin
          x = 0;
          next_line = 1'b1;
        end else begin
          screen[y * DEF_MAX_COLS + x] = ch;
          x++;
          if (x >= cols) begin
            x = 0;
            next_line = 1'b1;
          end
        end
        if (next_line) begin
          y++;
          if (y >= rows) begin
            // Only the configured columns move up; the bottom row is blanked.
            for (int r = 0; r + 1 < rows; r++)
              for (int c = 0; c < cols; c++)
                screen[r * DEF_MAX_COLS + c] = screen[(r + 1) * DEF_MAX_COLS + c];
            for (int c = 0; c < cols; c++) screen[(rows - 1) * DEF_MAX_COLS + c] = SPACE_CHAR;
            rep.scrolled = 1'b1;
            y--;
          end
        end
        col_pos = x;
        row_pos = y;
      end
      cell_index = col_pos + cols * row_pos;
      rep.col       = col_pos;
      rep.row       = row_pos;
      rep.high_byte = 8'(cell_index >> 8);
      rep.low_byte  = 8'(cell_index);
      expected_reports.push_back(rep);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      cursor_report_t want;
      cursor_report_t got;
      got = data[$bits(cursor_report_t)-1:0];
      if (expected_reports.size() == 0) begin
        failures++;
        if (failures <= 10) $display("Unexpected result item %h", data);
        return;
      end
      want = expected_reports.pop_front();
      if (got.col != want.col || got.row != want.row || got.high_byte != want.high_byte ||
          got.low_byte != want.low_byte || got.scrolled != want.scrolled ||
          got.read_char != want.read_char) begin
        failures++;
        if (failures <= 10)
          $display({"Mismatch (expected/actual): col %0d/%0d row %0d/%0d high %h/%h ",
                    "low %h/%h scrolled %0d/%0d char %h/%h"},
                   want.col, got.col, want.row, got.row, want.high_byte, got.high_byte,
                   want.low_byte, got.low_byte, want.scrolled, got.scrolled,
                   want.read_char, got.read_char);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [7:0]            cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  console_screen_tracker board;
  int cycle_count = 0;
  int ready_mode = 0;
  int mode_left = 0;

  text_console_writer_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready)
        board.note_item(in_tuser, in_tdata[7:0], in_tdata[12:8], in_tdata[19:13]);
      if (out_tvalid && out_tready) board.check_result(out_tdata);
    end
  end

  // The receiver switches between always ready, random stalls and long stalls.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 2);
      mode_left  <= $urandom_range(32, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send_item(logic func, logic [7:0] ch, logic [4:0] rrow, logic [6:0] rcol);
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {4'b0, rcol, rrow, ch};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic idle_cycles(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [7:0] rows_data, logic [7:0] cols_data);
    drain_results();
    repeat (8) @(posedge clk);
    write_cfg(CFG_ROWS, rows_data);
    write_cfg(CFG_COLS, cols_data);
  endtask

  task automatic run_phase(logic [7:0] rows_data, logic [7:0] cols_data, int count);
    int left;
    int burst;
    int pick;
    int rows;
    int cols;
    logic func;
    logic [7:0] ch;
    logic [4:0] rrow;
    logic [6:0] rcol;
    configure(rows_data, cols_data);
    rows = board.active_rows();
    cols = board.active_cols();
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && left > 0) begin
        pick = $urandom_range(0, 99);
        ch   = 8'($urandom_range(0, 255));
        rrow = 5'($urandom_range(0, 31));
        rcol = 7'($urandom_range(0, 127));
        func = FUNC_PUT;
        if (pick < 25) begin
          func = FUNC_READ;
          if ($urandom_range(0, 3) != 0) begin
            rrow = 5'($urandom_range(0, rows - 1));
            rcol = 7'($urandom_range(0, cols - 1));
          end
        end else if (pick < 40) begin
          ch = NEWLINE_CHAR;
        end
        send_item(func, ch, rrow, rcol);
        burst--;
        left--;
        if ($urandom_range(0, 199) == 0) drain_results();
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
    end
  endtask

  initial begin
    board = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_item(FUNC_READ, 8'h00, 5'd0, 7'd0);
    send_item(FUNC_READ, 8'hff, 5'd24, 7'd79);
    send_item(FUNC_READ, 8'h00, 5'd25, 7'd0);
    send_item(FUNC_READ, 8'h00, 5'd0, 7'd80);
    send_item(FUNC_READ, 8'h00, 5'd31, 7'd127);
    send_item(FUNC_PUT, 8'h00, 5'd0, 7'd0);
    send_item(FUNC_PUT, 8'hff, 5'd31, 7'd127);
    idle_cycles(3);
    send_item(FUNC_PUT, NEWLINE_CHAR, 5'd0, 7'd0);
    send_item(FUNC_PUT, 8'h41, 5'd0, 7'd0);
    send_item(FUNC_READ, 8'h00, 5'd0, 7'd0);
    send_item(FUNC_READ, 8'h00, 5'd0, 7'd1);
    send_item(FUNC_READ, 8'h00, 5'd1, 7'd0);

    // A three by four screen makes wrapping and scrolling cheap to reach.
    configure(8'd3, 8'd4);
    for (int i = 0; i < 4; i++) send_item(FUNC_PUT, 8'h61 + 8'(i), 5'd0, 7'd0);
    send_item(FUNC_PUT, NEWLINE_CHAR, 5'd0, 7'd0);
    for (int i = 0; i < 4; i++) send_item(FUNC_PUT, 8'h65 + 8'(i), 5'd0, 7'd0);
    send_item(FUNC_PUT, NEWLINE_CHAR, 5'd0, 7'd0);
    send_item(FUNC_READ, 8'h00, 5'd0, 7'd0);
    send_item(FUNC_READ, 8'h00, 5'd1, 7'd3);
    send_item(FUNC_READ, 8'h00, 5'd3, 7'd0);
    send_item(FUNC_READ, 8'h00, 5'd0, 7'd4);

    run_phase(8'd1, 8'd1, 80);
    run_phase(8'd0, 8'd0, 60);
    run_phase(8'd32, 8'd128, 40);
    run_phase(8'd63, 8'd255, 20);
    run_phase(8'd1, 8'd128, 60);
    run_phase(8'd32, 8'd1, 80);
    for (int p = 0; p < 8; p++) begin
      if ($urandom_range(0, 3) == 0)
        run_phase(8'($urandom_range(0, 63)), 8'($urandom_range(0, 8)), 100);
      else
        run_phase(8'($urandom_range(0, 10) | ($urandom_range(0, 3) << 6)),
                  8'($urandom_range(0, 24)), 100);
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
